// ===== hw/rtl/sle_pkg.sv =====
// Shared package of the script line table editor.
// Holds the channel payload types, command codes and the controller/datapath
// command and status structs. No dependencies.
package sle_pkg;

    localparam int SCRIPTS_DEF    = 11;
    localparam int LINES_DEF      = 6;
    localparam int MAX_TOKENS_DEF = 16;
    localparam int WORD_BITS_DEF  = 64;

    localparam int CMD_W     = 3;
    localparam int SCRIPT_W  = 4;
    localparam int LINE_W    = 3;
    localparam int PAYLOAD_W = 64;
    localparam int TOKEN_W   = 5;
    localparam int LENGTH_W  = 3;

    localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMMENT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    // read address select
    localparam logic RD_AT_LINE   = 1'b0;
    localparam logic RD_SHIFT_SRC = 1'b1;

    // write select
    localparam logic [1:0] WR_NEW     = 2'd0;
    localparam logic [1:0] WR_SHIFT   = 2'd1;
    localparam logic [1:0] WR_COMMENT = 2'd2;

    // length update
    localparam logic [2:0] LEN_HOLD      = 3'd0;
    localparam logic [2:0] LEN_OVERWRITE = 3'd1;
    localparam logic [2:0] LEN_INSERT    = 3'd2;
    localparam logic [2:0] LEN_DELETE    = 3'd3;
    localparam logic [2:0] LEN_CLEAR     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [SCRIPT_W-1:0]  script;
        logic [LINE_W-1:0]    line;
        logic [PAYLOAD_W-1:0] payload;
        logic [TOKEN_W-1:0]   token_count;
        logic                 comment_flag;
    } t_req;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] read_payload;
        logic [TOKEN_W-1:0]   read_tokens;
        logic                 read_comment;
        logic [LENGTH_W-1:0]  script_length;
        logic                 accepted;
    } t_rsp;

    typedef struct packed {
        logic       load_req;
        logic       load_ctx;
        logic       rd_en;
        logic       rd_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic [2:0] len_op;
        logic       clear_script;
        logic       blank;
        logic       idx_load;
        logic       idx_step;
        logic       set_ok;
        logic       res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             script_ok;
        logic             line_ok;
        logic             del_go;
        logic             del_shift;
        logic             ins_shift;
        logic             shift_more;
        logic             out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/sle_stream_if.sv =====
// Valid/ready stream interface used for the request and result channels.
// Payload type is a parameter; no other dependencies.
interface sle_stream_if #(parameter type t_data = logic);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sle_datapath.sv =====
// Datapath of the script line table editor: request registers, line memory
// with per-entry valid bits, script lengths, shift index and result register.
// Depends on sle_pkg.
module sle_datapath #(
    parameter int SCRIPTS    = sle_pkg::SCRIPTS_DEF,
    parameter int LINES      = sle_pkg::LINES_DEF,
    parameter int MAX_TOKENS = sle_pkg::MAX_TOKENS_DEF,
    parameter int WORD_BITS  = sle_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sle_pkg::t_dp_cmd  i_cmd,
    input  sle_pkg::t_req     i_req_data,
    output sle_pkg::t_dp_stat o_status,
    output logic              o_rsp_valid,
    output sle_pkg::t_rsp     o_rsp_data,
    input  logic              i_rsp_ready
);
    import sle_pkg::*;

    localparam int DEPTH = SCRIPTS * LINES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(LINES + 1);
    localparam int TW    = $clog2(MAX_TOKENS + 1);
    localparam int EW    = WORD_BITS + TW + 1;
    localparam int SIW   = (SCRIPTS > 1) ? $clog2(SCRIPTS) : 1;

    // request
    logic [CMD_W-1:0]     r_cmd;
    logic [SCRIPT_W-1:0]  r_script;
    logic [LINE_W-1:0]    r_line;
    logic [WORD_BITS-1:0] r_word;
    logic [TW-1:0]        r_tokens;
    logic                 r_comment;

    // per-item context
    logic [AW-1:0] r_base;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_idx;
    logic [LW-1:0] n_idx;
    logic          r_ok;

    // store
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_rdata;
    logic          r_rd_valid;
    logic [DEPTH-1:0] r_valid;
    logic [LW-1:0] r_lengths [SCRIPTS];
    logic [LW-1:0] n_len;

    logic          r_out_valid;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    logic            script_ok;
    logic            line_ok;
    logic [SIW-1:0]  s_idx;
    logic [LW-1:0]   ln;
    logic [LW-1:0]   len_prime;
    logic [LW-1:0]   len_one;
    logic [LW-1:0]   ins_len;
    logic [LW-1:0]   ow_len;
    logic [LW-1:0]   src_off;
    logic [LW-1:0]   rd_off;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   blank_addr;
    logic [EW-1:0]   rd_entry;
    logic [EW-1:0]   wr_data;
    logic [TW-1:0]   rd_tok;
    logic [TW-1:0]   sat_tokens;
    logic            is_del;
    logic            is_read;

    assign script_ok = int'(r_script) < SCRIPTS;
    assign line_ok   = int'(r_line) < LINES;
    assign s_idx     = r_script[SIW-1:0];
    assign ln        = LW'(r_line);
    assign is_del    = (r_cmd == CMD_DELETE);

    assign sat_tokens = (int'(i_req_data.token_count) > MAX_TOKENS) ?
                        TW'(MAX_TOKENS) : TW'(i_req_data.token_count);

    // lengths for the three editing operations
    assign len_prime = (r_len >= LW'(LINES)) ? LW'(LINES - 1) : r_len;
    assign len_one   = len_prime + LW'(1);
    assign ins_len   = (len_one < LW'(LINES) && ln >= len_one) ? len_one + LW'(1) : len_one;
    assign ow_len    = (r_len < LW'(LINES) && ln >= r_len) ? r_len + LW'(1) : r_len;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_load) begin
            n_idx = is_del ? ln : len_prime;
        end else if (i_cmd.idx_step) begin
            n_idx = is_del ? r_idx + LW'(1) : r_idx - LW'(1);
        end
    end

    // shift source sits one slot below (delete) or above (insert) the destination
    assign src_off    = is_del ? n_idx + LW'(1) : n_idx - LW'(1);
    assign rd_off     = (i_cmd.rd_sel == RD_SHIFT_SRC) ? src_off : ln;
    assign rd_addr    = r_base + AW'(rd_off);
    assign wr_addr    = r_base + AW'((i_cmd.wr_sel == WR_SHIFT) ? r_idx : ln);
    assign blank_addr = r_base + AW'(r_len - LW'(1));

    // never-written entries read as blank lines
    assign rd_entry = r_rd_valid ? r_rdata : '0;
    assign rd_tok   = rd_entry[WORD_BITS +: TW];

    always_comb begin
        case (i_cmd.wr_sel)
            WR_NEW:     wr_data = {r_comment, r_tokens, r_word};
            WR_SHIFT:   wr_data = rd_entry;
            WR_COMMENT: wr_data = {r_comment, rd_entry[EW-2:0]};
            default:    wr_data = rd_entry;
        endcase
    end

    always_comb begin
        case (i_cmd.len_op)
            LEN_OVERWRITE: n_len = ow_len;
            LEN_INSERT:    n_len = ins_len;
            LEN_DELETE:    n_len = r_len - LW'(1);
            LEN_CLEAR:     n_len = '0;
            default:       n_len = r_len;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_cmd     <= i_req_data.command;
            r_script  <= i_req_data.script;
            r_line    <= i_req_data.line;
            r_word    <= WORD_BITS'(i_req_data.payload);
            r_tokens  <= sat_tokens;
            r_comment <= i_req_data.comment_flag;
        end
        if (i_cmd.load_ctx) begin
            r_base <= AW'(int'(s_idx) * LINES);
            r_len  <= script_ok ? r_lengths[s_idx] : '0;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_ok       <= 1'b0;
            for (int s = 0; s < SCRIPTS; s++) begin
                r_lengths[s] <= '0;
            end
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[rd_addr];
            end
            for (int e = 0; e < DEPTH; e++) begin
                if (i_cmd.clear_script && e >= int'(r_base) && e < int'(r_base) + LINES) begin
                    r_valid[e] <= 1'b0;
                end
            end
            if (i_cmd.blank) begin
                r_valid[blank_addr] <= 1'b0;
            end
            if (i_cmd.wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.len_op != LEN_HOLD) begin
                r_lengths[s_idx] <= n_len;
            end
            if (i_cmd.load_req) begin
                r_ok <= 1'b0;
            end else if (i_cmd.set_ok) begin
                r_ok <= 1'b1;
            end
        end
    end

    // result register
    assign is_read = r_ok && (r_cmd == CMD_READ);

    always_comb begin
        n_rsp.read_payload  = is_read ? PAYLOAD_W'(rd_entry[WORD_BITS-1:0]) : '0;
        n_rsp.read_tokens   = is_read ? TOKEN_W'(rd_tok) : '0;
        n_rsp.read_comment  = is_read ? rd_entry[EW-1] : 1'b0;
        n_rsp.script_length = script_ok ? LENGTH_W'(r_lengths[s_idx]) : '0;
        n_rsp.accepted      = r_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_rsp;

    assign o_status.cmd        = r_cmd;
    assign o_status.script_ok  = script_ok;
    assign o_status.line_ok    = line_ok;
    assign o_status.del_go     = line_ok && (ln < r_len) && (rd_tok != '0);
    assign o_status.del_shift  = ((LW+1)'(ln) + (LW+1)'(1)) < (LW+1)'(r_len);
    assign o_status.ins_shift  = len_prime > ln;
    assign o_status.shift_more = is_del ?
                                 (((LW+1)'(r_idx) + (LW+1)'(2)) < (LW+1)'(r_len)) :
                                 ((LW+1)'(r_idx) > ((LW+1)'(ln) + (LW+1)'(1)));
    assign o_status.out_free   = !r_out_valid || i_rsp_ready;

    a_wr_in_script: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (wr_addr >= r_base) &&
            ((AW+1)'(wr_addr) < (AW+1)'(r_base) + (AW+1)'(LINES)))
        else $error("line write leaves the addressed script");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && i_cmd.wr_en) |-> (rd_addr != wr_addr))
        else $error("shift reads the slot it writes");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.load_ctx) |-> (r_len <= LW'(LINES)))
        else $error("script length above line count");

endmodule

// ===== hw/rtl/sle_ctrl.sv =====
// Controller of the script line table editor: sequences decode, memory reads,
// line shifts, writes and the result hand-off. Depends on sle_pkg.
module sle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sle_pkg::t_dp_stat i_status,
    output sle_pkg::t_dp_cmd  o_cmd
);
    import sle_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_DISPATCH   = 4'd2;
    localparam logic [3:0] S_READ_RES   = 4'd3;
    localparam logic [3:0] S_COMMENT_WR = 4'd4;
    localparam logic [3:0] S_DEL_CHECK  = 4'd5;
    localparam logic [3:0] S_SHIFT      = 4'd6;
    localparam logic [3:0] S_DEL_BLANK  = 4'd7;
    localparam logic [3:0] S_INS_WRITE  = 4'd8;
    localparam logic [3:0] S_DONE       = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_dp_cmd    cmd;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.load_ctx = 1'b1;
                n_state      = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                if (i_status.script_ok) begin
                    case (i_status.cmd)
                        CMD_READ: begin
                            if (i_status.line_ok) begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_AT_LINE;
                                n_state    = S_READ_RES;
                            end
                        end
                        CMD_OVERWRITE: begin
                            if (i_status.line_ok) begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WR_NEW;
                                cmd.len_op = LEN_OVERWRITE;
                                cmd.set_ok = 1'b1;
                            end
                        end
                        CMD_INSERT: begin
                            if (i_status.line_ok) begin
                                cmd.set_ok = 1'b1;
                                if (i_status.ins_shift) begin
                                    // prefetch the line above the last slot
                                    cmd.rd_en    = 1'b1;
                                    cmd.rd_sel   = RD_SHIFT_SRC;
                                    cmd.idx_load = 1'b1;
                                    n_state      = S_SHIFT;
                                end else begin
                                    n_state = S_INS_WRITE;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (i_status.line_ok) begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_AT_LINE;
                                n_state    = S_DEL_CHECK;
                            end
                        end
                        CMD_COMMENT: begin
                            if (i_status.line_ok) begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_AT_LINE;
                                n_state    = S_COMMENT_WR;
                            end
                        end
                        CMD_CLEAR: begin
                            cmd.clear_script = 1'b1;
                            cmd.len_op       = LEN_CLEAR;
                            cmd.set_ok       = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ_RES: begin
                cmd.set_ok = 1'b1;
                n_state    = S_DONE;
            end
            S_COMMENT_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_COMMENT;
                cmd.set_ok = 1'b1;
                n_state    = S_DONE;
            end
            S_DEL_CHECK: begin
                n_state = S_DONE;
                if (i_status.del_go) begin
                    cmd.set_ok = 1'b1;
                    cmd.len_op = LEN_DELETE;
                    if (i_status.del_shift) begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = RD_SHIFT_SRC;
                        cmd.idx_load = 1'b1;
                        n_state      = S_SHIFT;
                    end else begin
                        n_state = S_DEL_BLANK;
                    end
                end
            end
            S_SHIFT: begin
                // write the fetched line, fetch the next one
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                if (i_status.shift_more) begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_SHIFT_SRC;
                    cmd.idx_step = 1'b1;
                end else if (i_status.cmd == CMD_DELETE) begin
                    n_state = S_DEL_BLANK;
                end else begin
                    n_state = S_INS_WRITE;
                end
            end
            S_DEL_BLANK: begin
                cmd.blank = 1'b1;
                n_state   = S_DONE;
            end
            S_INS_WRITE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_NEW;
                cmd.len_op = LEN_INSERT;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (i_status.out_free) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

    a_shift_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |->
            (i_status.cmd == CMD_INSERT || i_status.cmd == CMD_DELETE))
        else $error("line shift outside insert or delete");

    a_shift_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && !i_status.shift_more) |=>
            (r_state == S_DEL_BLANK || r_state == S_INS_WRITE))
        else $error("line shift ends in a wrong state");

endmodule

// ===== hw/rtl/script_line_table_editor.sv =====
// Top level of the script line table editor.
// Depends on sle_pkg, sle_stream_if, sle_ctrl and sle_datapath.
//
//   channel  | dir | payload | meaning
//   ---------+-----+---------+----------------------------------------------
//   i_req    | in  | t_req   | one edit or read operation per item
//   o_rsp    | out | t_rsp   | one result item per request item
//
// One item at a time. Overwrite, clear and items dropped at decode go straight
// to the result register; read, set comment and delete first read the addressed
// line; insert and a delete that removes a line then shift up to LINES - 1 lines,
// one per cycle through the single read and write port of the line memory,
// before the new line is written (insert) or the freed last slot is blanked (delete).
// The next item is taken the cycle after the result is registered, even if
// o_rsp stalls; a stalled result holds only the final hand-off.
// Reset (synchronous, active low) clears all lines and lengths at once.
module script_line_table_editor #(
    parameter int SCRIPTS    = sle_pkg::SCRIPTS_DEF,
    parameter int LINES      = sle_pkg::LINES_DEF,
    parameter int MAX_TOKENS = sle_pkg::MAX_TOKENS_DEF,
    parameter int WORD_BITS  = sle_pkg::WORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sle_stream_if.sink    i_req,
    sle_stream_if.source  o_rsp
);
    import sle_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     rsp_valid;
    t_rsp     rsp_data;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sle_datapath #(
        .SCRIPTS    (SCRIPTS),
        .LINES      (LINES),
        .MAX_TOKENS (MAX_TOKENS),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_req_data  (i_req.data),
        .o_status    (dp_stat),
        .o_rsp_valid (rsp_valid),
        .o_rsp_data  (rsp_data),
        .i_rsp_ready (o_rsp.ready)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp_data;

endmodule

// ===== verif/script_line_table_editor_tb.sv =====
// Self-checking testbench of the script line table editor.
// Drives edit items through a directed table and a random run, predicts every result item or takes it from a typed row.
// Depends on sle_pkg, sle_stream_if and the script_line_table_editor RTL.
module script_line_table_editor_tb;
    import sle_pkg::*;

    localparam int N_SCRIPTS    = SCRIPTS_DEF;
    localparam int N_LINES      = LINES_DEF;
    localparam int TOKEN_CAP    = MAX_TOKENS_DEF;
    localparam int RANDOM_ITEMS = 1425;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 500000;

    // command codes the block does not decode
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    localparam logic [PAYLOAD_W-1:0] WORD_ONES = '1;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp typed_rsp;
    } t_edit_row;

    logic i_clk;
    logic i_rst_n;

    sle_stream_if #(.t_data(t_req)) req_if ();
    sle_stream_if #(.t_data(t_rsp)) rsp_if ();

    script_line_table_editor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the line store
    logic [PAYLOAD_W-1:0] cmd_word   [N_SCRIPTS][N_LINES];
    logic [TOKEN_W-1:0]   cmd_tokens [N_SCRIPTS][N_LINES];
    logic                 cmd_mark   [N_SCRIPTS][N_LINES];
    int                   shadow_len [N_SCRIPTS];

    t_rsp      pending_rsp[$];
    t_edit_row edit_table[$];

    int  mismatches = 0;
    int  items_sent;
    int  results_seen = 0;
    int  burst_left;
    int  cycle_count = 0;
    int  op_seen [8];
    int  full_drops;
    int  deletes_done;
    bit  hold_req;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d items still expected",
                     $time, cycle_count, pending_rsp.size());
            $display("** script_line_table_editor: FAILED **");
            $finish;
        end
    end

    function automatic void store_line(int s, int ln, logic [PAYLOAD_W-1:0] w,
                                       logic [TOKEN_W-1:0] tk, logic c);
        cmd_word[s][ln]   = w;
        cmd_tokens[s][ln] = tk;
        cmd_mark[s][ln]   = c;
        if (shadow_len[s] < N_LINES && ln >= shadow_len[s])
            shadow_len[s] = shadow_len[s] + 1;
    endfunction

    // Apply one edit to the shadow store and return the result item it yields.
    function automatic t_rsp apply_edit(t_req r);
        t_rsp               res;
        int                 s;
        int                 ln;
        int                 len;
        int                 i;
        logic [TOKEN_W-1:0] tk;
        res = '0;
        s   = int'(r.script);
        ln  = int'(r.line);
        tk  = (r.token_count > TOKEN_CAP) ? TOKEN_W'(TOKEN_CAP) : r.token_count;
        if (s >= N_SCRIPTS)
            return res;
        len = shadow_len[s];
        case (r.command)
            CMD_READ: begin
                if (ln < N_LINES) begin
                    res.read_payload = cmd_word[s][ln];
                    res.read_tokens  = cmd_tokens[s][ln];
                    res.read_comment = cmd_mark[s][ln];
                    res.accepted     = 1'b1;
                end
            end
            CMD_OVERWRITE: begin
                if (ln < N_LINES) begin
                    store_line(s, ln, r.payload, tk, r.comment_flag);
                    res.accepted = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (ln < N_LINES) begin
                    // full script: drop the last line, empty or not
                    if (len >= N_LINES) begin
                        len = N_LINES - 1;
                        cmd_word[s][len]   = '0;
                        cmd_tokens[s][len] = '0;
                        cmd_mark[s][len]   = 1'b0;
                        full_drops++;
                    end
                    for (i = len; i > ln; i--) begin
                        cmd_word[s][i]   = cmd_word[s][i-1];
                        cmd_tokens[s][i] = cmd_tokens[s][i-1];
                        cmd_mark[s][i]   = cmd_mark[s][i-1];
                    end
                    shadow_len[s] = len + 1;
                    store_line(s, ln, r.payload, tk, r.comment_flag);
                    res.accepted = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (ln < N_LINES && ln < len && cmd_tokens[s][ln] != 0) begin
                    len--;
                    shadow_len[s] = len;
                    for (i = ln; i < len; i++) begin
                        cmd_word[s][i]   = cmd_word[s][i+1];
                        cmd_tokens[s][i] = cmd_tokens[s][i+1];
                        cmd_mark[s][i]   = cmd_mark[s][i+1];
                    end
                    cmd_word[s][len]   = '0;
                    cmd_tokens[s][len] = '0;
                    cmd_mark[s][len]   = 1'b0;
                    deletes_done++;
                    res.accepted = 1'b1;
                end
            end
            CMD_COMMENT: begin
                if (ln < N_LINES) begin
                    cmd_mark[s][ln] = r.comment_flag;
                    res.accepted    = 1'b1;
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < N_LINES; i++) begin
                    cmd_word[s][i]   = '0;
                    cmd_tokens[s][i] = '0;
                    cmd_mark[s][i]   = 1'b0;
                end
                shadow_len[s] = 0;
                res.accepted  = 1'b1;
            end
            default: ;
        endcase
        res.script_length = LENGTH_W'(shadow_len[s]);
        return res;
    endfunction

    // Typed rows always carry zero read fields, so only length and accept are given.
    function automatic void add_row(logic [CMD_W-1:0] cmd, int s, int ln,
                                    logic [PAYLOAD_W-1:0] w, int tk, bit c,
                                    bit typed, int len, bit acc);
        t_edit_row row;
        row.req              = '0;
        row.req.command      = cmd;
        row.req.script       = SCRIPT_W'(s);
        row.req.line         = LINE_W'(ln);
        row.req.payload      = w;
        row.req.token_count  = TOKEN_W'(tk);
        row.req.comment_flag = c;
        row.typed            = typed;
        row.typed_rsp        = '0;
        row.typed_rsp.script_length = LENGTH_W'(len);
        row.typed_rsp.accepted      = acc;
        edit_table.push_back(row);
    endfunction

    task automatic offer_edit(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        int   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = apply_edit(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        op_seen[r.command]++;
        items_sent++;
    endtask

    task automatic flag_field(input string fld, input logic [PAYLOAD_W-1:0] exp_v,
                              input logic [PAYLOAD_W-1:0] act_v);
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, fld, exp_v, act_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            results_seen++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result item: expected none actual %0h", $time, got);
                mismatches++;
            end else begin
                want = pending_rsp.pop_front();
                if (got.read_payload !== want.read_payload)
                    flag_field("read_payload", want.read_payload, got.read_payload);
                if (got.read_tokens !== want.read_tokens)
                    flag_field("read_tokens", PAYLOAD_W'(want.read_tokens),
                               PAYLOAD_W'(got.read_tokens));
                if (got.read_comment !== want.read_comment)
                    flag_field("read_comment", PAYLOAD_W'(want.read_comment),
                               PAYLOAD_W'(got.read_comment));
                if (got.script_length !== want.script_length)
                    flag_field("script_length", PAYLOAD_W'(want.script_length),
                               PAYLOAD_W'(got.script_length));
                if (got.accepted !== want.accepted)
                    flag_field("accepted", PAYLOAD_W'(want.accepted),
                               PAYLOAD_W'(got.accepted));
            end
        end
    end

    // Result side: stall patterns in segments, plus one long hold on request.
    initial begin : rsp_side
        int  seg_left;
        int  mode;
        int  hold_left;
        bit  hold_taken;
        rsp_if.ready = 1'b0;
        seg_left   = 0;
        mode       = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ~rsp_if.ready;
                endcase
            end
        end
    end

    initial begin : stimulus
        t_req r;
        int   pick;
        int   cur_script;
        int   s;
        int   ln;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        i_rst_n      = 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        full_drops   = 0;
        deletes_done = 0;
        hold_req     = 1'b0;
        foreach (op_seen[i]) op_seen[i] = 0;
        for (s = 0; s < N_SCRIPTS; s++) begin
            shadow_len[s] = 0;
            for (ln = 0; ln < N_LINES; ln++) begin
                cmd_word[s][ln]   = '0;
                cmd_tokens[s][ln] = '0;
                cmd_mark[s][ln]   = 1'b0;
            end
        end

        //      command        scr ln payload                tk c  typed len acc
        add_row(CMD_READ,       0, 0, '0,                     0, 0, 1, 0, 1);
        add_row(CMD_READ,       0, 5, '0,                     0, 0, 1, 0, 1);
        add_row(CMD_READ,       0, 6, '0,                     0, 0, 1, 0, 0);
        add_row(CMD_OVERWRITE, 15, 0, WORD_ONES,             16, 1, 1, 0, 0);
        add_row(CMD_INSERT,    11, 0, WORD_ONES,              4, 1, 1, 0, 0);
        add_row(CMD_DELETE,    10, 7, '0,                     0, 0, 1, 0, 0);
        // token count above the cap saturates
        add_row(CMD_OVERWRITE,  0, 0, WORD_ONES,             31, 1, 1, 1, 1);
        add_row(CMD_READ,       0, 0, '0,                     0, 0, 0, 0, 0);
        // write past the end grows the length by one only
        add_row(CMD_OVERWRITE,  0, 4, '0,                     0, 0, 1, 2, 1);
        add_row(CMD_DELETE,     0, 1, '0,                     0, 0, 1, 2, 0);
        add_row(CMD_DELETE,     0, 3, '0,                     0, 0, 1, 2, 0);
        add_row(CMD_INSERT,     0, 0, 64'hA5A5_5A5A_0F0F_F0F0,  1, 0, 0, 0, 0);
        add_row(CMD_INSERT,     0, 5, 64'h8000_0000_0000_0001,  5, 1, 0, 0, 0);
        add_row(CMD_INSERT,     0, 2, 64'h0123_4567_89AB_CDEF, 16, 0, 0, 0, 0);
        add_row(CMD_INSERT,     0, 1, 64'hFEDC_BA98_7654_3210,  3, 1, 0, 0, 0);
        // full script: insert drops the last line, also when it is empty
        add_row(CMD_INSERT,     0, 0, 64'h5555_5555_5555_5555,  2, 0, 0, 0, 0);
        add_row(CMD_INSERT,     0, 3, 64'hAAAA_AAAA_AAAA_AAAA,  0, 1, 0, 0, 0);
        add_row(CMD_READ,       0, 5, '0,                     0, 0, 0, 0, 0);
        add_row(CMD_DELETE,     0, 0, '0,                     0, 0, 0, 0, 0);
        add_row(CMD_DELETE,     0, 4, '0,                     0, 0, 0, 0, 0);
        add_row(CMD_COMMENT,    0, 5, '0,                     0, 1, 0, 0, 0);
        add_row(CMD_COMMENT,    0, 7, '0,                     0, 1, 0, 0, 0);
        add_row(CMD_UNUSED_6,   0, 0, WORD_ONES,              7, 1, 0, 0, 0);
        add_row(CMD_UNUSED_7,  10, 0, WORD_ONES,              7, 1, 1, 0, 0);
        add_row(CMD_OVERWRITE, 10, 5, '0,                     0, 1, 1, 1, 1);
        add_row(CMD_CLEAR,     10, 7, '0,                     0, 0, 1, 0, 1);
        add_row(CMD_CLEAR,      0, 0, '0,                     0, 0, 1, 0, 1);
        add_row(CMD_READ,       0, 2, '0,                     0, 0, 1, 0, 1);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (edit_table[i])
            offer_edit(edit_table[i].req, edit_table[i].typed, edit_table[i].typed_rsp);

        cur_script = 0;
        repeat (RANDOM_ITEMS) begin
            r    = '0;
            pick = $urandom_range(0, 99);
            if (pick < 20)      r.command = CMD_READ;
            else if (pick < 42) r.command = CMD_OVERWRITE;
            else if (pick < 64) r.command = CMD_INSERT;
            else if (pick < 84) r.command = CMD_DELETE;
            else if (pick < 93) r.command = CMD_COMMENT;
            else if (pick < 97) r.command = CMD_CLEAR;
            else                r.command = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
            // stay on one script for a while so it fills up
            if ($urandom_range(0, 99) < 6) begin
                r.script = SCRIPT_W'($urandom_range(N_SCRIPTS, 15));
            end else begin
                if ($urandom_range(0, 99) < 25)
                    cur_script = $urandom_range(0, N_SCRIPTS - 1);
                r.script = SCRIPT_W'(cur_script);
            end
            r.line = ($urandom_range(0, 99) < 8) ? LINE_W'($urandom_range(N_LINES, 7))
                                                 : LINE_W'($urandom_range(0, N_LINES - 1));
            pick = $urandom_range(0, 19);
            if (pick == 0)      r.payload = '0;
            else if (pick == 1) r.payload = WORD_ONES;
            else                r.payload = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (pick == 0)      r.token_count = '0;
            else if (pick == 1) r.token_count = TOKEN_W'($urandom_range(TOKEN_CAP + 1, 31));
            else                r.token_count = TOKEN_W'($urandom_range(1, TOKEN_CAP));
            r.comment_flag = 1'($urandom_range(0, 1));
            if (items_sent == edit_table.size() + 60)
                hold_req = 1'b1;
            offer_edit(r, 1'b0, '0);
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d results: %0d reads, %0d overwrites, %0d inserts",
                 items_sent, results_seen, op_seen[CMD_READ], op_seen[CMD_OVERWRITE],
                 op_seen[CMD_INSERT]);
        $display("  %0d inserts into full scripts, %0d deletes done, %0d clears, %0d mismatches",
                 full_drops, deletes_done, op_seen[CMD_CLEAR], mismatches);
        if (mismatches == 0) begin
            $display("** script_line_table_editor: PASSED **");
        end else begin
            $display("** script_line_table_editor: FAILED **");
        end
        $finish;
    end

endmodule
